### rtl/e2q_pkg.sv
`timescale 1ns / 1ps
package e2q_pkg;

  localparam int unsigned AngleW = 32;
  localparam int unsigned QuatW  = 32;
  localparam int unsigned PhaseW = 32;
  // CORDIC datapath: Q30 magnitudes with headroom for gain growth.
  localparam int unsigned CordW  = 34;
  localparam int unsigned MaxSteps = 32;

  localparam logic [31:0] RadScale = 32'd2734261102;
  localparam logic [31:0] DegScale = 32'd1527099483;
  localparam logic signed [CordW-1:0] CordicX0 = 34'sd652032874;
  localparam logic signed [CordW-1:0] OneQ30   = 34'sd1073741824;

  typedef logic [31:0] atan_tab_t [MaxSteps];
  localparam atan_tab_t AtanTurns = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
    32'h00000000, 32'h00000000
  };

  typedef struct packed {
    logic signed [AngleW-1:0] yaw_angle;
    logic signed [AngleW-1:0] pitch_angle;
    logic signed [AngleW-1:0] roll_angle;
  } euler_t;

  typedef struct packed {
    logic signed [QuatW-1:0] quat_w;
    logic signed [QuatW-1:0] quat_x;
    logic signed [QuatW-1:0] quat_y;
    logic signed [QuatW-1:0] quat_z;
  } quat_t;

  // Cosine and sine of one half-angle, Q30, clamped.
  typedef struct packed {
    logic signed [31:0] c;
    logic signed [31:0] s;
  } cs_t;

  function automatic logic signed [CordW-1:0] clamp_q30(input logic signed [CordW-1:0] v);
    logic signed [CordW-1:0] r;
    r = v;
    if (v > OneQ30) r = OneQ30;
    if (v < -OneQ30) r = -OneQ30;
    return r;
  endfunction

endpackage

### rtl/e2q_if.sv
`timescale 1ns / 1ps
interface e2q_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/e2q_phase.sv
`timescale 1ns / 1ps
// Scales one angle to a half-angle phase in 2^-32 turn, two stages.
module e2q_phase #(
  parameter int unsigned ANGLE_FRACTION_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     deg_i,
  input  logic signed [31:0]       angle_i,
  output logic [31:0]              phase_o
);
  localparam int unsigned ShRad = ANGLE_FRACTION_BITS + 3;
  localparam int unsigned ShDeg = ANGLE_FRACTION_BITS + 8;

  logic signed [64:0] prod_d, prod_q;
  logic               deg_q;
  logic signed [64:0] sum_rad, sum_deg;

  always_comb begin
    prod_d = 65'(angle_i) * $signed({1'b0, (deg_i ? e2q_pkg::DegScale : e2q_pkg::RadScale)});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      deg_q  <= deg_i;
    end
  end

  assign sum_rad = (prod_q + (65'sd1 <<< (ShRad - 1))) >>> ShRad;
  assign sum_deg = (prod_q + (65'sd1 <<< (ShDeg - 1))) >>> ShDeg;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      phase_o <= deg_q ? sum_deg[31:0] : sum_rad[31:0];
    end
  end
endmodule

### rtl/e2q_cordic.sv
`timescale 1ns / 1ps
// Unrolled rotation CORDIC, one register stage per iteration.
module e2q_cordic #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [31:0]       phase_i,
  output e2q_pkg::cs_t      cs_o
);
  localparam int unsigned Steps = (CORDIC_STEPS > e2q_pkg::MaxSteps) ?
                                  e2q_pkg::MaxSteps : CORDIC_STEPS;
  localparam int unsigned W = e2q_pkg::CordW;

  logic signed [W-1:0] x_q [Steps+1];
  logic signed [W-1:0] y_q [Steps+1];
  logic signed [W-1:0] z_q [Steps+1];
  logic [1:0]          quad_q [Steps+1];
  logic signed [W-1:0] c_d, s_d;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= e2q_pkg::CordicX0;
      y_q[0]    <= '0;
      z_q[0]    <= W'({2'b00, phase_i[29:0]});
      quad_q[0] <= phase_i[31:30];
    end
  end

  for (genvar i = 0; i < Steps; i++) begin : g_step
    logic signed [W-1:0] at;
    assign at = W'(e2q_pkg::AtanTurns[i]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quad_q[i+1] <= quad_q[i];
        if (!z_q[i][W-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - at;
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + at;
        end
      end
    end
  end

  always_comb begin
    case (quad_q[Steps])
      2'd0:    begin c_d = x_q[Steps];  s_d = y_q[Steps];  end
      2'd1:    begin c_d = -y_q[Steps]; s_d = x_q[Steps];  end
      2'd2:    begin c_d = -x_q[Steps]; s_d = -y_q[Steps]; end
      default: begin c_d = y_q[Steps];  s_d = -x_q[Steps]; end
    endcase
  end

  logic signed [W-1:0] cc, sc;
  assign cc = e2q_pkg::clamp_q30(c_d);
  assign sc = e2q_pkg::clamp_q30(s_d);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cs_o.c <= cc[31:0];
      cs_o.s <= sc[31:0];
    end
  end
endmodule

### rtl/e2q_combine.sv
`timescale 1ns / 1ps
// Hamilton products: pair products, registered, then the cross sums.
module e2q_combine (
  input  logic          clk_i,
  input  logic          en_i,
  input  e2q_pkg::cs_t  yaw_i,
  input  e2q_pkg::cs_t  pitch_i,
  input  e2q_pkg::cs_t  roll_i,
  output e2q_pkg::quat_t quat_o
);
  localparam int unsigned PW = 64;
  localparam logic signed [PW-1:0] Half = 64'sd1 <<< 29;

  logic signed [PW-1:0] crcp_p, srsp_p, srcp_p, crsp_p;
  logic signed [31:0] crcp_q, srsp_q, srcp_q, crsp_q;
  logic signed [31:0] cy_q, sy_q;
  logic signed [PW-1:0] m_d [8];
  logic signed [PW-1:0] m_q [8];
  logic signed [PW-1:0] r_d [4];
  logic signed [PW-1:0] rd [4];
  logic signed [e2q_pkg::CordW-1:0] sat [4];

  assign crcp_p = (64'(roll_i.c) * 64'(pitch_i.c) + Half) >>> 30;
  assign srsp_p = (64'(roll_i.s) * 64'(pitch_i.s) + Half) >>> 30;
  assign srcp_p = (64'(roll_i.s) * 64'(pitch_i.c) + Half) >>> 30;
  assign crsp_p = (64'(roll_i.c) * 64'(pitch_i.s) + Half) >>> 30;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      crcp_q <= crcp_p[31:0];
      srsp_q <= srsp_p[31:0];
      srcp_q <= srcp_p[31:0];
      crsp_q <= crsp_p[31:0];
      cy_q   <= yaw_i.c;
      sy_q   <= yaw_i.s;
    end
  end

  assign m_d[0] = 64'(crcp_q) * 64'(cy_q);
  assign m_d[1] = 64'(srsp_q) * 64'(sy_q);
  assign m_d[2] = 64'(srcp_q) * 64'(cy_q);
  assign m_d[3] = 64'(crsp_q) * 64'(sy_q);
  assign m_d[4] = 64'(crsp_q) * 64'(cy_q);
  assign m_d[5] = 64'(srcp_q) * 64'(sy_q);
  assign m_d[6] = 64'(crcp_q) * 64'(sy_q);
  assign m_d[7] = 64'(srsp_q) * 64'(cy_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q <= m_d;
    end
  end

  assign r_d[0] = m_q[0] + m_q[1];
  assign r_d[1] = m_q[2] - m_q[3];
  assign r_d[2] = m_q[4] + m_q[5];
  assign r_d[3] = m_q[6] - m_q[7];

  for (genvar k = 0; k < 4; k++) begin : g_out
    assign rd[k]  = (r_d[k] + Half) >>> 30;
    assign sat[k] = e2q_pkg::clamp_q30(rd[k][e2q_pkg::CordW-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quat_o.quat_w <= sat[0][31:0];
      quat_o.quat_x <= sat[1][31:0];
      quat_o.quat_y <= sat[2][31:0];
      quat_o.quat_z <= sat[3][31:0];
    end
  end
endmodule

### rtl/euler_to_quaternion.sv
`timescale 1ns / 1ps
// Throughput: one item per cycle; the whole pipeline advances together
// and holds when the output is stalled.
// Reset: rst_ni clears valid bits and selects radians (use_degrees = 0).
// Data registers are not reset.
module euler_to_quaternion #(
  parameter int unsigned CORDIC_STEPS = 24,
  parameter int unsigned ANGLE_FRACTION_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  e2q_if.sink   in_if,
  e2q_if.source out_if
);
  localparam int unsigned Steps = (CORDIC_STEPS > e2q_pkg::MaxSteps) ?
                                  e2q_pkg::MaxSteps : CORDIC_STEPS;
  localparam int unsigned Depth = Steps + 7;

  logic use_degrees_q;
  logic [Depth-1:0] vld_q;
  logic en;
  logic [31:0] ph_y, ph_p, ph_r;
  e2q_pkg::cs_t cs_y, cs_p, cs_r;
  e2q_pkg::euler_t ang;

  // The pipeline moves whenever the last stage is empty or being taken.
  assign en = !vld_q[Depth-1] || out_if.ready;
  assign in_if.ready = en;
  assign out_if.valid = vld_q[Depth-1];
  assign ang = in_if.data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_degrees_q <= 1'b0;
      vld_q <= '0;
    end else begin
      if (cfg_we_i) use_degrees_q <= cfg_wdata_i;
      if (en) vld_q <= {vld_q[Depth-2:0], in_if.valid};
    end
  end

  e2q_phase #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_ph_y (
    .clk_i, .en_i(en), .deg_i(use_degrees_q), .angle_i(ang.yaw_angle), .phase_o(ph_y));
  e2q_phase #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_ph_p (
    .clk_i, .en_i(en), .deg_i(use_degrees_q), .angle_i(ang.pitch_angle), .phase_o(ph_p));
  e2q_phase #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_ph_r (
    .clk_i, .en_i(en), .deg_i(use_degrees_q), .angle_i(ang.roll_angle), .phase_o(ph_r));

  e2q_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_co_y (
    .clk_i, .en_i(en), .phase_i(ph_y), .cs_o(cs_y));
  e2q_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_co_p (
    .clk_i, .en_i(en), .phase_i(ph_p), .cs_o(cs_p));
  e2q_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_co_r (
    .clk_i, .en_i(en), .phase_i(ph_r), .cs_o(cs_r));

  e2q_combine u_comb (
    .clk_i, .en_i(en), .yaw_i(cs_y), .pitch_i(cs_p), .roll_i(cs_r), .quat_o(out_if.data));

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid)
    else $error("result dropped while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[Depth-1] |-> in_if.ready)
    else $error("pipeline stalled with empty output stage");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (out_if.data.quat_w <= 32'sd1073741824 &&
                      out_if.data.quat_w >= -32'sd1073741824))
    else $error("quat_w out of range");
endmodule

### tb/sv/euler_to_quaternion_tb.sv
`timescale 1ns / 1ps
module euler_to_quaternion_tb;

  localparam int unsigned Steps = 24;
  localparam int unsigned FracBits = 16;
  localparam int unsigned Latency = Steps + 7;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  e2q_if #(.T(e2q_pkg::euler_t)) angles_if ();
  e2q_if #(.T(e2q_pkg::quat_t)) quat_if ();

  euler_to_quaternion #(
    .CORDIC_STEPS(Steps),
    .ANGLE_FRACTION_BITS(FracBits)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if(angles_if.sink),
    .out_if(quat_if.source)
  );

  typedef struct {
    e2q_pkg::euler_t ang;
    bit              has_quat;
    e2q_pkg::quat_t  quat;
  } angle_row_t;

  bit      deg_mode;
  e2q_pkg::quat_t quat_pending[$];
  int      mismatches;
  int      quats_checked;
  int      angles_sent;
  int      send_idle_pct;
  int      recv_idle_pct;
  bit      recv_hold;
  bit      recv_stalled;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #200_000_000;
    $display("euler_to_quaternion regression: fail");
    $finish;
  end

  function automatic longint rnd_q30(longint v);
    return (v + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint clip_q30(longint v);
    if (v > 64'sd1073741824) return 64'sd1073741824;
    if (v < -64'sd1073741824) return -64'sd1073741824;
    return v;
  endfunction

  // Half-angle as a 32-bit fraction of a turn; the wrap does the modulo.
  function automatic logic [31:0] turn_phase(logic signed [31:0] ang);
    logic [63:0] prod;
    int unsigned sh;
    sh = deg_mode ? FracBits + 8 : FracBits + 3;
    prod = 64'($signed(ang)) * (deg_mode ? 64'd1527099483 : 64'd2734261102);
    prod = prod + (64'd1 << (sh - 1));
    return prod[sh +: 32];
  endfunction

  task automatic half_cos_sin(input logic signed [31:0] ang, output longint c,
                              output longint s);
    logic [31:0] ph;
    longint x, y, z, dx, dy;
    ph = turn_phase(ang);
    x = 652032874;
    y = 0;
    z = longint'(ph[29:0]);
    for (int i = 0; i < (Steps > 32 ? 32 : Steps); i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(e2q_pkg::AtanTurns[i]);
      end else begin
        x += dx; y -= dy; z += longint'(e2q_pkg::AtanTurns[i]);
      end
    end
    case (ph[31:30])
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    c = clip_q30(c);
    s = clip_q30(s);
  endtask

  task automatic predict_quat(input e2q_pkg::euler_t a, output e2q_pkg::quat_t q);
    longint cy, sy, cp, sp, cr, sr, crcp, srsp, srcp, crsp;
    half_cos_sin(a.yaw_angle, cy, sy);
    half_cos_sin(a.pitch_angle, cp, sp);
    half_cos_sin(a.roll_angle, cr, sr);
    crcp = rnd_q30(cr * cp);
    srsp = rnd_q30(sr * sp);
    srcp = rnd_q30(sr * cp);
    crsp = rnd_q30(cr * sp);
    q.quat_w = 32'(clip_q30(rnd_q30(crcp * cy + srsp * sy)));
    q.quat_x = 32'(clip_q30(rnd_q30(srcp * cy - crsp * sy)));
    q.quat_y = 32'(clip_q30(rnd_q30(crsp * cy + srcp * sy)));
    q.quat_z = 32'(clip_q30(rnd_q30(crcp * sy - srsp * cy)));
  endtask

  // Expectations are queued at the accepting edge, so the pipeline can never
  // deliver a result ahead of them.
  always @(posedge clk_i) begin
    e2q_pkg::quat_t exp_q;
    if (rst_ni && angles_if.valid && angles_if.ready) begin
      predict_quat(angles_if.data, exp_q);
      quat_pending.push_back(exp_q);
      angles_sent++;
    end
    if (rst_ni && quat_if.valid && quat_if.ready) begin
      if (quat_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected quaternion %h", quat_if.data);
      end else begin
        exp_q = quat_pending.pop_front();
        quats_checked++;
        if (exp_q !== quat_if.data) begin
          mismatches++;
          if (mismatches <= 10)
            $display("quat mismatch exp w=%0d x=%0d y=%0d z=%0d got w=%0d x=%0d y=%0d z=%0d",
                     exp_q.quat_w, exp_q.quat_x, exp_q.quat_y, exp_q.quat_z,
                     quat_if.data.quat_w, quat_if.data.quat_x, quat_if.data.quat_y,
                     quat_if.data.quat_z);
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when requested.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quat_if.ready <= 1'b0;
    end else begin
      quat_if.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    recv_hold = 1'b0;
    recv_stalled = 1'b0;
    wait (angles_sent >= 400);
    @(posedge clk_i);
    recv_hold <= 1'b1;
    repeat (300) @(posedge clk_i);
    recv_hold <= 1'b0;
    recv_stalled = 1'b1;
  end

  task automatic send_angles(input e2q_pkg::euler_t a);
    while ($urandom_range(99) < send_idle_pct) begin
      angles_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    angles_if.valid <= 1'b1;
    angles_if.data <= a;
    @(posedge clk_i);
    while (!angles_if.ready) @(posedge clk_i);
  endtask

  task automatic drain_and_idle();
    angles_if.valid <= 1'b0;
    @(posedge clk_i);
    while (quat_pending.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic write_units(input bit deg);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= deg;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    deg_mode = deg;
  endtask

  function automatic logic signed [31:0] rand_angle(bit deg);
    case ($urandom_range(9))
      0: return $urandom;
      1: return 32'sh8000_0000;
      2: return 32'sh7fff_ffff;
      // Mostly within about two turns either way, where the quadrants are all exercised.
      default: return deg ? $signed($urandom_range(1440 << 16)) - (720 <<< 16)
                          : $signed($urandom_range(26 << 16)) - (13 <<< 16);
    endcase
  endfunction

  angle_row_t angle_rows[] = '{
    '{'{32'sd0, 32'sd0, 32'sd0}, 1'b0, '{0, 0, 0, 0}},
    '{'{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff}, 1'b0, '{0, 0, 0, 0}},
    '{'{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000}, 1'b0, '{0, 0, 0, 0}},
    '{'{32'sh7fff_ffff, 32'sh8000_0000, 32'sd0}, 1'b0, '{0, 0, 0, 0}},
    '{'{32'sd205887, 32'sd0, 32'sd0}, 1'b0, '{0, 0, 0, 0}},
    '{'{32'sd0, 32'sd102944, 32'sd0}, 1'b0, '{0, 0, 0, 0}},
    '{'{32'sd0, 32'sd0, -32'sd102944}, 1'b0, '{0, 0, 0, 0}},
    '{'{32'sd411775, 32'sd411775, 32'sd411775}, 1'b0, '{0, 0, 0, 0}},
    '{'{-32'sd1, 32'sd1, -32'sd65536}, 1'b0, '{0, 0, 0, 0}},
    '{'{32'sd11796480, 32'sd5898240, -32'sd5898240}, 1'b0, '{0, 0, 0, 0}},
    '{'{32'sd23592960, 32'sd0, 32'sd0}, 1'b0, '{0, 0, 0, 0}},
    '{'{32'sd1234567, -32'sd7654321, 32'sd3141592}, 1'b0, '{0, 0, 0, 0}}
  };

  initial begin
    e2q_pkg::quat_t exp_q;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    angles_if.valid = 1'b0;
    angles_if.data = '0;
    deg_mode = 1'b0;
    mismatches = 0;
    quats_checked = 0;
    angles_sent = 0;
    send_idle_pct = 23;
    recv_idle_pct = 78;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows in both unit modes; rows marked has_quat are cross-checked here (none are marked).
    for (int m = 0; m < 2; m++) begin
      if (m == 1) write_units(1'b1);
      foreach (angle_rows[r]) begin
        if (angle_rows[r].has_quat) begin
          predict_quat(angle_rows[r].ang, exp_q);
          if (exp_q !== angle_rows[r].quat) begin
            mismatches++;
            $display("identity row predicts %h", exp_q);
          end
        end
        send_angles(angle_rows[r].ang);
      end
      drain_and_idle();
    end
    write_units(1'b0);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = ph == 0 ? 23 : (ph == 1 ? 78 : 0);
      recv_idle_pct = ph == 0 ? 78 : (ph == 1 ? 23 : 0);
      for (int n = 0; n < 340; n++) begin
        e2q_pkg::euler_t a;
        a.yaw_angle = rand_angle(deg_mode);
        a.pitch_angle = rand_angle(deg_mode);
        a.roll_angle = rand_angle(deg_mode);
        send_angles(a);
        if (n == 169) begin
          drain_and_idle();
          write_units(!deg_mode);
        end
      end
      drain_and_idle();
    end
    wait (recv_stalled);

    $display("%0d angle sets sent, %0d quaternions checked over both unit modes,",
             angles_sent, quats_checked);
    $display("extreme angles, mixed stalls and a long output hold-off.");
    if (mismatches == 0 && quat_pending.size() == 0) begin
      $display("euler_to_quaternion regression: pass");
    end else begin
      $display("euler_to_quaternion regression: fail");
    end
    $finish;
  end

endmodule

### euler_to_quaternion.f
rtl/e2q_pkg.sv
rtl/e2q_if.sv
rtl/e2q_phase.sv
rtl/e2q_cordic.sv
rtl/e2q_combine.sv
rtl/euler_to_quaternion.sv
tb/sv/euler_to_quaternion_tb.sv
